>>> hdl/sbr_pkg.sv
package sbr_pkg;

  // Fixed field widths
  localparam int IDX_W  = 32;
  localparam int BYTE_W = 8;
  localparam int CAP_W  = 7;
  localparam int PEND_W = 7;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // One incoming request
  typedef struct packed {
    logic              has_byte;
    logic [IDX_W-1:0]  stream_index;
    logic [BYTE_W-1:0] byte_value;
    logic              ends_stream;
    logic [IDX_W-1:0]  consumer_total;
  } item_t;

  // One outgoing result
  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic [PEND_W-1:0] pending_bytes;
    logic              stream_closed;
  } result_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_CHECK,
    ST_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // latch the request at the port
    logic eval;        // register window check and slot
    logic apply;       // store the byte, mark the end
    logic drain;       // pop the head slot, start store read
    logic load_byte;   // load result with the byte read
    logic load_empty;  // load result carrying no byte
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic head_held;   // slot of next expected index is held
    logic out_free;    // result register can take a new value
  } stat_t;

endpackage

>>> hdl/sbr_ram.sv
module sbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/sbr_ctrl.sv
module sbr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  sbr_pkg::stat_t stat,
  output sbr_pkg::cmd_t  cmd
);

  sbr_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sbr_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = sbr_pkg::ST_EVAL;
        end
      end
      sbr_pkg::ST_EVAL: begin
        state_next = sbr_pkg::ST_APPLY;
      end
      sbr_pkg::ST_APPLY: begin
        state_next = sbr_pkg::ST_CHECK;
      end
      sbr_pkg::ST_CHECK: begin
        if (stat.out_free) begin
          state_next = stat.head_held ? sbr_pkg::ST_LOAD : sbr_pkg::ST_IDLE;
        end
      end
      sbr_pkg::ST_LOAD: begin
        // more of the run is held: go pop the next slot
        state_next = stat.head_held ? sbr_pkg::ST_CHECK : sbr_pkg::ST_IDLE;
      end
      default: begin
        state_next = sbr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      sbr_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.take   = item_valid;
      end
      sbr_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      sbr_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
      end
      sbr_pkg::ST_CHECK: begin
        cmd.drain      = stat.out_free && stat.head_held;
        cmd.load_empty = stat.out_free && !stat.head_held;
      end
      sbr_pkg::ST_LOAD: begin
        cmd.load_byte = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hdl/sbr_dp.sv
module sbr_dp #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sbr_pkg::item_t               item,
  input  logic                         cfg_wr_en,
  input  logic [sbr_pkg::CAP_W-1:0]    cfg_wr_data,
  input  sbr_pkg::cmd_t                cmd,
  output sbr_pkg::stat_t               stat,
  output logic                         result_valid,
  input  logic                         result_ready,
  output sbr_pkg::result_t             result
);

  localparam int SW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  // Control state
  logic [sbr_pkg::CAP_W-1:0] cap;
  logic [STORE_DEPTH-1:0]    held;
  logic [sbr_pkg::IDX_W-1:0] ne;
  logic [SW-1:0]             ne_slot;
  logic [CW-1:0]             count;
  logic                      end_seen;
  logic                      closed;
  logic                      res_valid;

  // Payload state
  sbr_pkg::item_t            item_q;
  logic                      keep;
  logic [SW-1:0]             slot;
  sbr_pkg::result_t          res;

  // Combinational
  logic [sbr_pkg::IDX_W-1:0] diff;
  logic [sbr_pkg::IDX_W:0]   limit;
  logic                      in_win;
  logic [SW:0]               slot_sum;
  logic [SW-1:0]             slot_calc;
  logic [SW-1:0]             ne_slot_inc;
  logic                      head_held;
  logic                      closed_new;
  logic                      store_wr;
  logic [sbr_pkg::BYTE_W-1:0] rd_data;

  // Acceptance window: at or past next expected, below reader total plus
  // capacity (no wrap), and within the slot store
  always_comb begin
    diff   = item_q.stream_index - ne;
    limit  = (sbr_pkg::IDX_W+1)'(item_q.consumer_total) + (sbr_pkg::IDX_W+1)'(cap);
    in_win = item_q.has_byte && (item_q.stream_index >= ne) &&
             ((sbr_pkg::IDX_W+1)'(item_q.stream_index) < limit) &&
             (diff < sbr_pkg::IDX_W'(STORE_DEPTH));
  end

  // Slot = (ne mod depth + offset) mod depth, offset below depth
  always_comb begin
    slot_sum = {1'b0, ne_slot} + {1'b0, diff[SW-1:0]};
    if (slot_sum >= (SW+1)'(STORE_DEPTH)) begin
      slot_calc = SW'(slot_sum - (SW+1)'(STORE_DEPTH));
    end else begin
      slot_calc = slot_sum[SW-1:0];
    end
  end

  assign ne_slot_inc = (ne_slot == SW'(STORE_DEPTH - 1)) ? '0 : ne_slot + SW'(1);
  assign head_held   = held[ne_slot];
  assign closed_new  = closed || (end_seen && (count == '0));
  assign store_wr    = cmd.apply && !closed && keep && !held[slot];

  assign stat.head_held = head_held;
  assign stat.out_free  = !res_valid || result_ready;

  // Byte store
  sbr_ram #(
    .WIDTH(sbr_pkg::BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (store_wr),
    .wr_addr(slot),
    .wr_data(item_q.byte_value),
    .rd_en  (cmd.drain),
    .rd_addr(ne_slot),
    .rd_data(rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= sbr_pkg::CAP_RESET;
      held      <= '0;
      ne        <= '0;
      ne_slot   <= '0;
      count     <= '0;
      end_seen  <= 1'b0;
      closed    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      // store a new byte; a held slot keeps its first value
      if (cmd.apply && !closed) begin
        if (!item_q.has_byte && item_q.ends_stream) begin
          end_seen <= 1'b1;
        end
        if (keep) begin
          if (!held[slot]) begin
            held[slot] <= 1'b1;
            count      <= count + CW'(1);
          end
          if (item_q.ends_stream) begin
            end_seen <= 1'b1;
          end
        end
      end
      // pop the head of the run
      if (cmd.drain) begin
        held[ne_slot] <= 1'b0;
        count         <= count - CW'(1);
        ne            <= ne + sbr_pkg::IDX_W'(1);
        ne_slot       <= ne_slot_inc;
        closed        <= end_seen && (count == CW'(1));
      end
      if (cmd.load_empty) begin
        closed <= closed_new;
      end
      // result register
      if (cmd.load_byte || cmd.load_empty) begin
        res_valid <= 1'b1;
      end else if (result_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_q <= item;
    end
    if (cmd.eval) begin
      keep <= in_win;
      slot <= slot_calc;
    end
    if (cmd.load_empty) begin
      res.out_valid     <= 1'b0;
      res.out_byte      <= '0;
      res.last_of_run   <= 1'b1;
      res.pending_bytes <= sbr_pkg::PEND_W'(count);
      res.stream_closed <= closed_new;
    end else if (cmd.load_byte) begin
      res.out_valid     <= 1'b1;
      res.out_byte      <= rd_data;
      res.last_of_run   <= !head_held;
      res.pending_bytes <= sbr_pkg::PEND_W'(count);
      res.stream_closed <= closed;
    end
  end

  assign result_valid = res_valid;
  assign result       = res;

endmodule

>>> hdl/stream_byte_reassembler_core.sv
// Stream byte reassembler: puts out-of-order stream bytes back in order.
// Request channel (item_valid/item_ready/item): one byte or empty segment
// with its absolute 32-bit index and the reader's running total. Result
// channel (result_valid/result_ready/result): one result per delivered
// byte, or a single byte-less result when nothing drains; last_of_run
// marks the final result of a request.
// Config: cfg_wr_en/cfg_wr_data write the 7-bit stream capacity at once.
// One request at a time: after acceptance the controller steps through
// EVAL, APPLY and CHECK. A request that drains nothing gets its byte-less
// result in CHECK; for each drained byte CHECK pops the head slot and
// starts the registered read of the slot store, and LOAD loads the byte
// read. The next request is taken only after the last result is loaded.
// When result_ready is low the result register holds its value and the
// controller waits before the next store read; nothing is dropped.
// Reset (rst, synchronous) clears the held bits, next expected index,
// count and end/closed flags and sets capacity to 64; there is no
// clearing pass, the block takes a request on the first cycle after reset.
// Once closed, every request is answered by one byte-less closed result.
module stream_byte_reassembler_core #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  sbr_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output sbr_pkg::result_t          result,
  input  logic                      cfg_wr_en,
  input  logic [sbr_pkg::CAP_W-1:0] cfg_wr_data
);

  sbr_pkg::cmd_t  cmd;
  sbr_pkg::stat_t stat;

  sbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbr_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

>>> hdl/sbr_checker.sv
module sbr_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input sbr_pkg::result_t result
);

  // Sticky copy of a delivered closed flag
  logic closed_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_seen <= 1'b0;
    end else if (result_valid && result_ready && result.stream_closed) begin
      closed_seen <= 1'b1;
    end
  end

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // One request in flight: no request taken right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request taken while another is in progress");

  // A result without a byte ends its run and carries a zero byte
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_valid |-> result.last_of_run && (result.out_byte == '0))
    else $error("byte-less result malformed");

  // Closed stays closed
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && closed_seen |-> result.stream_closed)
    else $error("stream reopened");

endmodule

bind stream_byte_reassembler_core sbr_checker u_sbr_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);
